// ===== src/lbs_pkg.sv =====
package lbs_pkg;

  // Row width in cells; fixed by the stream format.
  localparam int unsigned ROW_W = 64;
  // Width of the grid_width register.
  localparam int unsigned WIDTH_W = 7;
  // Column count after reset: every column in use.
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 7'd64;

  // One result word as it leaves the row engine.
  typedef struct packed {
    logic [ROW_W-1:0] next_row;
    logic             final_result;
  } res_t;

endpackage

// ===== src/lbs_if.sv =====
interface lbs_row_if;
  import lbs_pkg::*;

  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_cells;
  logic             last_row;

  modport source (output valid, output row_cells, output last_row, input ready);
  modport sink (input valid, input row_cells, input last_row, output ready);
endinterface

interface lbs_res_if;
  import lbs_pkg::*;

  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] next_row;
  logic             final_result;

  modport source (output valid, output next_row, output final_result, input ready);
  modport sink (input valid, input next_row, input final_result, output ready);
endinterface

interface lbs_cfg_if;
  import lbs_pkg::*;

  logic               valid;
  logic               ready;
  logic [WIDTH_W-1:0] grid_width;

  modport source (output valid, output grid_width, input ready);
  modport sink (input valid, input grid_width, output ready);
endinterface

// ===== src/lbs_core.sv =====
module lbs_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  lbs_row_if.sink                     row_i,
  input  logic [lbs_pkg::WIDTH_W-1:0] grid_width_i,
  output logic                        emit_valid_o,
  output lbs_pkg::res_t               emit_o,
  input  logic                        emit_ready_i
);
  import lbs_pkg::*;

  // Columns below the configured width are in use.
  function automatic logic [ROW_W-1:0] col_mask(input logic [WIDTH_W-1:0] w);
    logic [ROW_W-1:0] m;
    for (int c = 0; c < ROW_W; c++) begin
      m[c] = (w > WIDTH_W'(c));
    end
    return m;
  endfunction

  // One generation for the middle row: survive on zero neighbors, born on two.
  function automatic logic [ROW_W-1:0] next_gen(input logic [ROW_W-1:0] up_raw,
                                                input logic [ROW_W-1:0] mid_raw,
                                                input logic [ROW_W-1:0] dn_raw,
                                                input logic [ROW_W-1:0] mask);
    logic [ROW_W-1:0] up, mid, dn, res;
    logic [ROW_W-1:0] ul, ur, ml, mr, dl, dr;
    logic [3:0]       n;
    up  = up_raw & mask;
    mid = mid_raw & mask;
    dn  = dn_raw & mask;
    // Shifted copies put the left and right neighbors under each column.
    ul  = {up[ROW_W-2:0], 1'b0};
    ur  = {1'b0, up[ROW_W-1:1]};
    ml  = {mid[ROW_W-2:0], 1'b0};
    mr  = {1'b0, mid[ROW_W-1:1]};
    dl  = {dn[ROW_W-2:0], 1'b0};
    dr  = {1'b0, dn[ROW_W-1:1]};
    res = '0;
    for (int c = 0; c < ROW_W; c++) begin
      n = 4'(ul[c]) + 4'(up[c]) + 4'(ur[c]) + 4'(ml[c]) + 4'(mr[c])
        + 4'(dl[c]) + 4'(dn[c]) + 4'(dr[c]);
      res[c] = (mid[c] && n == 4'd0) || (!mid[c] && n == 4'd2);
    end
    return res & mask;
  endfunction

  logic             stg_vld_q;
  logic [ROW_W-1:0] stg_row_q;
  logic             stg_last_q;
  logic [ROW_W-1:0] upper_q, upper_d;
  logic [ROW_W-1:0] middle_q, middle_d;
  logic             mid_vld_q, mid_vld_d;
  logic             flush_q, flush_d;

  logic [ROW_W-1:0] mask;
  logic [ROW_W-1:0] cur;
  logic             need_emit, advance, consume;
  logic [ROW_W-1:0] sel_up, sel_mid, sel_dn;

  assign mask = col_mask(grid_width_i);
  assign cur  = stg_row_q & mask;

  assign need_emit = stg_vld_q && (mid_vld_q || stg_last_q);
  assign advance   = stg_vld_q && (!need_emit || emit_ready_i);
  // A last row behind a buffered row takes a second step for its own result.
  assign consume   = advance && (flush_q || !(stg_last_q && mid_vld_q));

  assign row_i.ready = !stg_vld_q || consume;

  always_comb begin
    if (flush_q) begin
      sel_up  = upper_q;
      sel_mid = middle_q;
      sel_dn  = '0;
    end else if (mid_vld_q) begin
      sel_up  = upper_q;
      sel_mid = middle_q;
      sel_dn  = cur;
    end else begin
      sel_up  = '0;
      sel_mid = cur;
      sel_dn  = '0;
    end
  end

  assign emit_valid_o        = need_emit;
  assign emit_o.next_row     = next_gen(sel_up, sel_mid, sel_dn, mask);
  assign emit_o.final_result = flush_q || !mid_vld_q;

  always_comb begin
    upper_d   = upper_q;
    middle_d  = middle_q;
    mid_vld_d = mid_vld_q;
    flush_d   = flush_q;
    if (advance) begin
      if (flush_q) begin
        upper_d   = '0;
        middle_d  = '0;
        mid_vld_d = 1'b0;
        flush_d   = 1'b0;
      end else if (stg_last_q && !mid_vld_q) begin
        upper_d   = '0;
        middle_d  = '0;
        mid_vld_d = 1'b0;
      end else begin
        upper_d   = mid_vld_q ? middle_q : '0;
        middle_d  = cur;
        mid_vld_d = 1'b1;
        flush_d   = stg_last_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
      mid_vld_q <= 1'b0;
      flush_q   <= 1'b0;
      upper_q   <= '0;
      middle_q  <= '0;
    end else begin
      mid_vld_q <= mid_vld_d;
      flush_q   <= flush_d;
      upper_q   <= upper_d;
      middle_q  <= middle_d;
      if (row_i.valid && row_i.ready) begin
        stg_vld_q <= 1'b1;
      end else if (consume) begin
        stg_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_i.valid && row_i.ready) begin
      stg_row_q  <= row_i.row_cells;
      stg_last_q <= row_i.last_row;
    end
  end

  // The second step of a last row always sits on that row with a row buffered.
  a_flush_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> (stg_vld_q && stg_last_q && mid_vld_q))
    else $error("flush step without a buffered last row");

  // After the final result of a grid goes out, nothing stays buffered.
  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit_o.final_result && need_emit) |=> (!mid_vld_q && !flush_q))
    else $error("row buffers not cleared after final result");

  // A row is never dropped while its result still has to be sent.
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (need_emit && !emit_ready_i) |=> (stg_vld_q && $stable(flush_q)))
    else $error("row lost while output was stalled");

endmodule

// ===== src/lbs_skid.sv =====
module lbs_skid (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          up_valid_i,
  input  lbs_pkg::res_t up_data_i,
  output logic          up_ready_o,
  lbs_res_if.source     res_o
);
  import lbs_pkg::*;

  logic out_vld_q;
  res_t out_q;
  logic skid_vld_q;
  res_t skid_q;
  logic out_free;

  assign up_ready_o = !skid_vld_q;
  assign out_free   = !out_vld_q || res_o.ready;

  assign res_o.valid        = out_vld_q;
  assign res_o.next_row     = out_q.next_row;
  assign res_o.final_result = out_q.final_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= up_valid_i;
      end
    end else if (up_valid_i && !skid_vld_q) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (up_valid_i) begin
        out_q <= up_data_i;
      end
    end else if (up_valid_i && !skid_vld_q) begin
      skid_q <= up_data_i;
    end
  end

  // The spare word is only used while the output word is held.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("spare word without an output word");

  // A stalled output word with a word arriving must fill the spare slot.
  a_skid_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !res_o.ready && up_valid_i && up_ready_o) |=> skid_vld_q)
    else $error("incoming word dropped while output stalled");

  // A freed spare slot hands its word straight to the output.
  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && res_o.ready) |=> (out_vld_q && !skid_vld_q))
    else $error("spare word not moved to output");

endmodule

// ===== src/life_like_b2s0_row_generation.sv =====
// Result path: a result word is worked out from the row engine's staging register and
//   registered in the output buffer.
// Throughput: one row per cycle unless the output stalls; a last row after a buffered row
//   takes a second step, because the row engine sends its two words through one output port.
// Reset (rst_ni, asynchronous, active low): no row buffered, output empty, and
//   grid_width set to 64 so that every column is in use.
module life_like_b2s0_row_generation (
  input  logic       clk_i,
  input  logic       rst_ni,
  lbs_cfg_if.sink    cfg_i,
  lbs_row_if.sink    row_i,
  lbs_res_if.source  res_o
);
  import lbs_pkg::*;

  // The column count register. The user must write it only while the block is idle;
  // the block itself does not enforce this. Its ready is tied high, so it is always taken.
  logic [WIDTH_W-1:0] grid_width_q;

  // Handshake between the row engine and the output buffer.
  logic emit_valid;
  logic emit_ready;
  res_t emit_word;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q <= WIDTH_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      grid_width_q <= cfg_i.grid_width;
    end
  end

  // The row engine registers each incoming row, keeps the two rows above it,
  // and works out the next generation of the middle row in one pass of
  // neighbor-count logic. Its ready depends only on registered state of the
  // output buffer, so no combinational path runs from res_o.ready to row_i.ready.
  lbs_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .row_i        (row_i),
    .grid_width_i (grid_width_q),
    .emit_valid_o (emit_valid),
    .emit_o       (emit_word),
    .emit_ready_i (emit_ready)
  );

  // The output register plus a spare word lets the engine hand over one more
  // result while the downstream side stalls; once both hold a word, the engine
  // stalls on its next result until the output drains.
  lbs_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (emit_valid),
    .up_data_i  (emit_word),
    .up_ready_o (emit_ready),
    .res_o      (res_o)
  );

endmodule

// ===== bench/tb_life_like_b2s0_row_generation.sv =====
module tb_life_like_b2s0_row_generation;
  timeunit 1ns;
  timeprecision 1ps;

  import lbs_pkg::*;

  // A live cell survives only with this many live neighbors; a dead cell is
  // born with exactly BIRTH_COUNT live neighbors.
  localparam int SURVIVE_COUNT = 0;
  localparam int BIRTH_COUNT   = 2;
  // Cycles that pass after the last expected word before the width register
  // is written. A row that opens a grid produces no word, so the block may
  // still be busy with it when the queue runs empty. The block lets go of
  // such a row once it has moved it into its row buffer.
  localparam int SETTLE_CYCLES = 4;
  // Cycles to wait after the final word before the verdict.
  localparam int DRAIN_CYCLES  = 8;
  // Mismatch lines printed before the report task only counts.
  localparam int MAX_REPORTS   = 40;

  logic clk_i = 1'b0;
  logic rst_ni;

  lbs_cfg_if cfg ();
  lbs_row_if row ();
  lbs_res_if res ();

  life_like_b2s0_row_generation dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .row_i  (row),
    .res_o  (res)
  );

  // 4 ns clock: two delays, one per half period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predicted grid state. These mirror what the block holds: the row above
  // the buffered row, the buffered row itself, whether a row is buffered,
  // and the column count in force.
  logic [ROW_W-1:0]   above_row   = '0;
  logic [ROW_W-1:0]   center_row  = '0;
  logic               center_held = 1'b0;
  logic [WIDTH_W-1:0] width_reg   = WIDTH_RESET;

  // Next-generation words still owed by the block, oldest first.
  res_t pending_gens[$];

  int mismatches = 0;
  int words_seen = 0;

  // Idling controls. The sender and the receiver each insert short random
  // bursts of idle cycles when their flag is set. A nonzero hold request makes
  // the receiver stall for that many cycles in one stretch.
  bit tx_idle_on     = 1'b0;
  bit rx_idle_on     = 1'b0;
  int ready_hold_req = 0;

  // Columns in use for a given register value. Values above the row width
  // act as the full row, and zero leaves no column in use.
  function automatic logic [ROW_W-1:0] col_mask(input logic [WIDTH_W-1:0] w);
    if (w >= ROW_W) return '1;
    return (ROW_W'(1) << w) - ROW_W'(1);
  endfunction

  // A cell outside the row reads as dead; the edges do not wrap.
  function automatic int cell_at(input logic [ROW_W-1:0] r, input int c);
    if (c < 0 || c >= ROW_W) return 0;
    return int'(r[c]);
  endfunction

  // One generation of the middle row under B2/S0, with the rows above and
  // below it, all masked again with the width in force now.
  function automatic logic [ROW_W-1:0] life_next(input logic [ROW_W-1:0] up,
                                                 input logic [ROW_W-1:0] mid,
                                                 input logic [ROW_W-1:0] dn,
                                                 input logic [WIDTH_W-1:0] w);
    logic [ROW_W-1:0] keep;
    logic [ROW_W-1:0] nxt;
    int cnt;
    keep = col_mask(w);
    up   = up & keep;
    mid  = mid & keep;
    dn   = dn & keep;
    nxt  = '0;
    for (int c = 0; c < ROW_W; c++) begin
      cnt = cell_at(up, c - 1) + cell_at(up, c) + cell_at(up, c + 1)
          + cell_at(mid, c - 1) + cell_at(mid, c + 1)
          + cell_at(dn, c - 1) + cell_at(dn, c) + cell_at(dn, c + 1);
      nxt[c] = mid[c] ? (cnt == SURVIVE_COUNT) : (cnt == BIRTH_COUNT);
    end
    return nxt & keep;
  endfunction

  // Advances the predicted grid by one accepted row and queues the words it
  // causes. A buffered row is finished once the row below it arrives. A last
  // row is finished at once against an empty row below, flagged as final,
  // and the buffers start over for the next grid.
  task automatic advance_grid(input logic [ROW_W-1:0] cells, input logic last);
    logic [ROW_W-1:0] cur;
    cur = cells & col_mask(width_reg);
    if (center_held) begin
      pending_gens.push_back({life_next(above_row, center_row, cur, width_reg), 1'b0});
      above_row = center_row;
    end else begin
      above_row = '0;
    end
    center_row  = cur;
    center_held = 1'b1;
    if (last) begin
      pending_gens.push_back({life_next(above_row, center_row, '0, width_reg), 1'b1});
      above_row   = '0;
      center_row  = '0;
      center_held = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Offers one row and returns at the edge that accepts it. Valid stays high
  // so that a following row can go out on the very next cycle; only an idle
  // burst, a register write or the end of the run lowers it.
  task automatic send_row(input logic [ROW_W-1:0] cells, input logic last);
    int gap;
    row.valid     <= 1'b1;
    row.row_cells <= cells;
    row.last_row  <= last;
    do @(posedge clk_i); while (!row.ready);
    advance_grid(cells, last);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      row.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Writes the width register once the block is idle: every owed word has
  // arrived and the block has had time to settle a row that owed none.
  task automatic write_width(input logic [WIDTH_W-1:0] w);
    row.valid <= 1'b0;
    while (pending_gens.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg.valid      <= 1'b1;
    cfg.grid_width <= w;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    width_reg = w;
  endtask

  // Row contents with a spread of densities. Sparse rows matter most, since
  // births need exactly two neighbors and survival needs none.
  function automatic logic [ROW_W-1:0] random_row();
    logic [ROW_W-1:0] a, b, c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:         return '0;
      1:         return '1;
      2, 3:      return a;
      4, 5, 6:   return a & b;
      7, 8:      return a & b & c;
      default:   return a | b;
    endcase
  endfunction

  // Receiver. Ready is redrawn at every edge: a long hold when one is
  // requested, else short random stalls while idling is enabled.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (ready_hold_req != 0) begin
        hold_left      = ready_hold_req;
        ready_hold_req = 0;
      end
      if (hold_left != 0) begin
        res.ready <= 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        res.ready <= 1'b0;
        stall_left--;
      end else begin
        res.ready <= 1'b1;
        if (rx_idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 4);
      end
    end
  end

  // Checker. Every word taken from the block is matched against the oldest
  // owed word, field by field.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res.valid && res.ready) begin
      words_seen++;
      if (pending_gens.size() == 0) begin
        report_mismatch($sformatf("word %0d not expected: next_row=%h final_result=%b",
                                  words_seen, res.next_row, res.final_result));
      end else begin
        want = pending_gens.pop_front();
        if (res.next_row !== want.next_row)
          report_mismatch($sformatf("word %0d next_row=%h, expected %h",
                                    words_seen, res.next_row, want.next_row));
        if (res.final_result !== want.final_result)
          report_mismatch($sformatf("word %0d final_result=%b, expected %b",
                                    words_seen, res.final_result, want.final_result));
      end
    end
  end

  // Default width after reset, with no register write yet: single-row grids,
  // edge columns, the full row, and short grids that make births at the edges.
  task automatic test_reset_width();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    // Single-row grids: an isolated cell at each edge survives, a full row dies.
    send_row(64'h8000_0000_0000_0001, 1'b1);
    send_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_row(64'h0000_0000_0000_0000, 1'b1);
    // Births in the first and last columns from cells in the rows around.
    send_row(64'h4000_0000_0000_0002, 1'b0);
    send_row(64'h0000_0000_0000_0000, 1'b0);
    send_row(64'h4000_0000_0000_0002, 1'b1);
    // Checkerboard rows: every cell has one to three live neighbors.
    send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_row(64'h5555_5555_5555_5555, 1'b1);
    // Pairs two apart in one row give births above and below them.
    send_row(64'h0000_0000_0000_0000, 1'b0);
    send_row(64'h8000_0005_0000_0005, 1'b0);
    send_row(64'h0000_0000_0000_0000, 1'b1);
  endtask

  // Narrowest, zero, over-range (acting as full) and one-below-full widths. The high columns of the
  // input rows must be ignored and the same columns of the result be zero.
  task automatic test_width_extremes();
    logic [WIDTH_W-1:0] widths[5] = '{7'd1, 7'd0, 7'd127, 7'd65, 7'd63};
    foreach (widths[i]) begin
      write_width(widths[i]);
      send_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_row(64'h8000_0000_0000_0005, 1'b1);
    end
  endtask

  // The width changes while a grid is half done: the buffered rows are masked
  // again with the new width when they are used.
  task automatic test_width_midgrid();
    write_width(7'd64);
    send_row(64'h8421_0842_1084_2108, 1'b0);
    send_row(64'hFFFF_0000_FFFF_0000, 1'b0);
    write_width(7'd12);
    send_row(64'h0000_0000_0000_0A05, 1'b1);
  endtask

  // The receiver holds off for a long stretch while rows keep coming, so the
  // block fills up and stalls its input; then everything drains.
  task automatic test_backpressure();
    int len;
    int sent;
    write_width(7'd64);
    tx_idle_on     = 1'b0;
    rx_idle_on     = 1'b0;
    ready_hold_req = 80;
    sent = 0;
    while (sent < 40) begin
      len = $urandom_range(1, 6);
      for (int k = 0; k < len; k++) send_row(random_row(), k == len - 1);
      sent += len;
    end
  endtask

  // One phase of random grids at a fixed width. Most grids are short; a few
  // run long. The phase always closes its last grid.
  task automatic run_random_phase(input logic [WIDTH_W-1:0] w, input int n_rows,
                                  input bit tx_idle, input bit rx_idle);
    int len;
    int sent;
    write_width(w);
    tx_idle_on = tx_idle;
    rx_idle_on = rx_idle;
    sent = 0;
    while (sent < n_rows) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int k = 0; k < len; k++) send_row(random_row(), k == len - 1);
      sent += len;
    end
  endtask

  // Random grids over a run of widths, including the extremes. The closing
  // phase runs at full rate on both sides.
  task automatic test_random_grids();
    run_random_phase(7'd64, 260, 1'b1, 1'b1);
    run_random_phase(7'($urandom_range(33, 63)), 260, 1'b1, 1'b0);
    run_random_phase(7'd1, 120, 1'b1, 1'b1);
    run_random_phase(7'($urandom_range(2, 32)), 260, 1'b0, 1'b1);
    run_random_phase(7'($urandom_range(65, 127)), 200, 1'b1, 1'b1);
    run_random_phase(7'd0, 80, 1'b1, 1'b1);
    run_random_phase(7'd3, 150, 1'b0, 1'b0);
    run_random_phase(7'($urandom_range(1, 64)), 260, 1'b1, 1'b1);
    run_random_phase(7'd64, 300, 1'b0, 1'b0);
  endtask

  initial begin
    rst_ni         <= 1'b0;
    row.valid      <= 1'b0;
    row.row_cells  <= '0;
    row.last_row   <= 1'b0;
    cfg.valid      <= 1'b0;
    cfg.grid_width <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_width();
    test_width_extremes();
    test_width_midgrid();
    test_backpressure();
    test_random_grids();

    // Let every owed word arrive, then give the block time to show any
    // stray word before the verdict.
    row.valid <= 1'b0;
    while (pending_gens.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Guard against a hung handshake: far beyond the slowest correct run.
  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
